// ===== rtl/khc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// khc_pkg
// shared constants, payload types and control types of the key press heat map
// colorizer
// ----------------------------------------------------------------------------
package khc_pkg;

   localparam int ROWS          = 8;
   localparam int COLS          = 8;
   localparam int COUNT_BITS    = 16;

   localparam int NKEYS         = ROWS * COLS;
   localparam int KEY_W         = (NKEYS > 1) ? $clog2(NKEYS) : 1;
   localparam int ROW_W         = 3;
   localparam int COL_W         = 3;
   localparam int CH_W          = 8;

   localparam int RAMP_STEP     = 255;
   localparam int RAMP_SEGMENTS = 4;
   localparam int V_MAX         = RAMP_SEGMENTS * RAMP_STEP;
   localparam int Q_W           = 10;
   localparam int NUM_W         = COUNT_BITS + Q_W;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [ROW_W-1:0] key_row;
      logic [COL_W-1:0] key_col;
      logic             pressed;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0] led_row;
      logic [COL_W-1:0] led_col;
      logic [CH_W-1:0]  red;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  blue;
      logic             last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
   } meta_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_KEY,
      ST_UPDATE,
      ST_SWEEP,
      ST_DRAIN
   } ctrl_state_type;

   typedef struct packed {
      logic             rd_en;
      logic [KEY_W-1:0] rd_addr;
      logic             update;
      logic [KEY_W-1:0] wr_addr;
      logic             sweep;
      meta_type         meta;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pipe_busy;
   } dp_status_type;

endpackage : khc_pkg
`default_nettype wire

// ===== rtl/key_press_heatmap_colorizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// key_press_heatmap_colorizer
// counts key presses on the key grid and repaints every key as a heat color
// scaled against the highest count
// ----------------------------------------------------------------------------
//  channel   ports                       handshake
//  request   start, busy, req_data       taken when start high and busy low
//  result    rsp_strobe, rsp_data        one cycle per result, cannot stall
//
//  a press inside the grid reads and updates its counter (states rd_key and
//  update), then makes one counter ram read per key (64 keys), then the
//  multiplier and the ten-stage divider pipeline drain.
//  releases and keys outside the grid are dropped in the cycle they arrive.
//  reset clears all counters and the highest count at once (valid bits).
//  results leave one per cycle in row-major order, last key flagged.
// ----------------------------------------------------------------------------
module key_press_heatmap_colorizer (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  khc_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output khc_pkg::rsp_type  rsp_data
);

   khc_pkg::ctrl_cmd_type  cmd;
   khc_pkg::dp_status_type status;

   khc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   khc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule : key_press_heatmap_colorizer
`default_nettype wire

// ===== rtl/khc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// khc_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module khc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire                                         clock,
   input  wire                                         wr_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]                            wr_data,
   input  wire                                         rd_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : khc_ram
`default_nettype wire

// ===== rtl/khc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// khc_ctrl
// sequencer: filters requests, runs the counter update and sweeps all keys
// ----------------------------------------------------------------------------
module khc_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  khc_pkg::req_type       req_data,
   input  khc_pkg::dp_status_type status,
   output logic                   busy,
   output khc_pkg::ctrl_cmd_type  cmd
);

   khc_pkg::ctrl_state_type state_ff, state_in;
   logic [khc_pkg::KEY_W-1:0] key_ff, key_in;
   logic [khc_pkg::KEY_W-1:0] addr_ff, addr_in;
   logic [khc_pkg::ROW_W-1:0] row_ff, row_in;
   logic [khc_pkg::COL_W-1:0] col_ff, col_in;
   logic                      req_ok;
   logic                      sweep_last;
   logic                      col_last;

   assign req_ok = req_data.pressed
                   && ({1'b0, req_data.key_row} < (khc_pkg::ROW_W + 1)'(khc_pkg::ROWS))
                   && ({1'b0, req_data.key_col} < (khc_pkg::COL_W + 1)'(khc_pkg::COLS));
   assign sweep_last = (addr_ff == khc_pkg::KEY_W'(khc_pkg::NKEYS - 1));
   assign col_last   = (col_ff == khc_pkg::COL_W'(khc_pkg::COLS - 1));
   assign busy       = (state_ff != khc_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= khc_pkg::ST_IDLE;
         key_ff   <= '0;
         addr_ff  <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         key_ff   <= key_in;
         addr_ff  <= addr_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      addr_in      = addr_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cmd          = '0;
      cmd.wr_addr  = key_ff;
      cmd.rd_addr  = addr_ff;
      cmd.meta.row = row_ff;
      cmd.meta.col = col_ff;
      cmd.meta.last = sweep_last;
      unique case (state_ff)
         khc_pkg::ST_IDLE: begin
            if (start && req_ok) begin
               key_in   = khc_pkg::KEY_W'(req_data.key_row) * khc_pkg::KEY_W'(khc_pkg::COLS)
                          + khc_pkg::KEY_W'(req_data.key_col);
               state_in = khc_pkg::ST_RD_KEY;
            end
         end
         khc_pkg::ST_RD_KEY: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = key_ff;
            state_in    = khc_pkg::ST_UPDATE;
         end
         khc_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            addr_in    = '0;
            row_in     = '0;
            col_in     = '0;
            state_in   = khc_pkg::ST_SWEEP;
         end
         khc_pkg::ST_SWEEP: begin
            cmd.rd_en = 1'b1;
            cmd.sweep = 1'b1;
            addr_in   = addr_ff + 1'b1;
            if (col_last) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
            if (sweep_last) begin
               state_in = khc_pkg::ST_DRAIN;
            end
         end
         khc_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = khc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = khc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule : khc_ctrl
`default_nettype wire

// ===== rtl/khc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// khc_datapath
// counter store, highest count, scale multiplier, pipelined divider and
// color ramp with the result register
// ----------------------------------------------------------------------------
module khc_datapath (
   input  wire                    clock,
   input  wire                    reset,
   input  khc_pkg::ctrl_cmd_type  cmd,
   output khc_pkg::dp_status_type status,
   output logic                   rsp_strobe,
   output khc_pkg::rsp_type       rsp_data
);

   localparam int CB = khc_pkg::COUNT_BITS;
   localparam int QW = khc_pkg::Q_W;
   localparam int NW = khc_pkg::NUM_W;

   logic [khc_pkg::NKEYS-1:0] cnt_valid_ff;
   logic [CB-1:0]             highest_ff;
   logic                      rd_valid_ff;
   logic [CB-1:0]             ram_rd_data;
   logic [CB-1:0]             count;
   logic [CB-1:0]             count_inc;

   logic                      rd_vld_ff;
   khc_pkg::meta_type         rd_meta_ff;

   // stage 0 holds the scaled count, stage j the j-th quotient bit
   logic [NW-1:0]             rem_ff  [QW+1];
   logic [NW-1:0]             rem_in  [QW+1];
   logic [QW-1:0]             quo_ff  [QW+1];
   logic [QW-1:0]             quo_in  [QW+1];
   logic [QW:0]               vld_ff;
   khc_pkg::meta_type         meta_ff [QW+1];

   logic [NW-1:0]             div_sh  [QW+1];
   logic [QW-1:0]             v;
   logic [khc_pkg::CH_W-1:0]  red, green, blue;

   logic                      strobe_ff;
   khc_pkg::rsp_type          rsp_ff;

   khc_ram #(
      .WIDTH (CB),
      .DEPTH (khc_pkg::NKEYS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (cmd.wr_addr),
      .wr_data (count_inc),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (ram_rd_data)
   );

   // an entry never written reads as zero
   assign count     = rd_valid_ff ? ram_rd_data : '0;
   assign count_inc = (count == khc_pkg::COUNT_MAX) ? count : count + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_valid_ff <= '0;
         highest_ff   <= '0;
         rd_valid_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         vld_ff       <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         if (cmd.update) begin
            cnt_valid_ff[cmd.wr_addr] <= 1'b1;
            if (count_inc > highest_ff) begin
               highest_ff <= count_inc;
            end
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= cnt_valid_ff[cmd.rd_addr];
         end
         rd_vld_ff <= cmd.sweep;
         vld_ff    <= {vld_ff[QW-1:0], rd_vld_ff};
         strobe_ff <= vld_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      rd_meta_ff <= cmd.meta;
      rem_ff[0]  <= NW'(count) * NW'(khc_pkg::V_MAX);
      quo_ff[0]  <= '0;
      meta_ff[0] <= rd_meta_ff;
      for (int j = 1; j <= QW; j++) begin
         rem_ff[j]  <= rem_in[j];
         quo_ff[j]  <= quo_in[j];
         meta_ff[j] <= meta_ff[j-1];
      end
      rsp_ff.led_row     <= meta_ff[QW].row;
      rsp_ff.led_col     <= meta_ff[QW].col;
      rsp_ff.red         <= red;
      rsp_ff.green       <= green;
      rsp_ff.blue        <= blue;
      rsp_ff.last_of_run <= meta_ff[QW].last;
   end

   // restoring division, one quotient bit per stage, msb first
   always_comb begin
      rem_in[0] = '0;
      quo_in[0] = '0;
      div_sh[0] = '0;
      for (int j = 1; j <= QW; j++) begin
         div_sh[j] = NW'(highest_ff) << (QW - j);
         if (rem_ff[j-1] >= div_sh[j]) begin
            rem_in[j] = rem_ff[j-1] - div_sh[j];
            quo_in[j] = {quo_ff[j-1][QW-2:0], 1'b1};
         end else begin
            rem_in[j] = rem_ff[j-1];
            quo_in[j] = {quo_ff[j-1][QW-2:0], 1'b0};
         end
      end
   end

   assign v = quo_ff[QW];

   always_comb begin
      red   = '0;
      green = '0;
      blue  = '0;
      priority if (v <= QW'(khc_pkg::RAMP_STEP)) begin
         green = v[khc_pkg::CH_W-1:0];
         blue  = khc_pkg::CH_W'(khc_pkg::RAMP_STEP);
      end else if (v <= QW'(2 * khc_pkg::RAMP_STEP)) begin
         green = khc_pkg::CH_W'(khc_pkg::RAMP_STEP);
         blue  = khc_pkg::CH_W'(QW'(2 * khc_pkg::RAMP_STEP) - v);
      end else if (v <= QW'(3 * khc_pkg::RAMP_STEP)) begin
         red   = khc_pkg::CH_W'(v - QW'(2 * khc_pkg::RAMP_STEP));
         green = khc_pkg::CH_W'(khc_pkg::RAMP_STEP);
      end else begin
         red   = khc_pkg::CH_W'(khc_pkg::RAMP_STEP);
         green = khc_pkg::CH_W'(QW'(khc_pkg::V_MAX) - v);
      end
   end

   assign status.pipe_busy = rd_vld_ff | (|vld_ff);
   assign rsp_strobe       = strobe_ff;
   assign rsp_data         = rsp_ff;

endmodule : khc_datapath
`default_nettype wire

// ===== tb/key_press_heatmap_colorizer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_press_heatmap_colorizer_test
// drives key press and release requests into the heat map colorizer, keeps a
// running copy of the per-key counters and the highest count, and checks
// every painted key color, in row-major order, against that copy
// ----------------------------------------------------------------------------
module key_press_heatmap_colorizer_test;
   import khc_pkg::*;

   typedef enum logic [1:0] {
      PAINT_BY_MODEL,
      PAINT_NONE,
      PAINT_LONE_HOT
   } paint_check_type;

   typedef struct packed {
      req_type         req;
      paint_check_type check;
   } plan_row_type;

   localparam int PLAN_ROWS    = 16;
   localparam int RANDOM_ITEMS = 194;

   // directed requests: corners, segment boundaries and releases
   plan_row_type plan [PLAN_ROWS] = '{
      '{'{3'd7, 3'd7, 1'b1}, PAINT_LONE_HOT},
      '{'{3'd0, 3'd0, 1'b0}, PAINT_NONE},
      '{'{3'd7, 3'd7, 1'b0}, PAINT_NONE},
      '{'{3'd0, 3'd0, 1'b1}, PAINT_BY_MODEL},
      '{'{3'd0, 3'd0, 1'b1}, PAINT_BY_MODEL},
      '{'{3'd0, 3'd0, 1'b1}, PAINT_BY_MODEL},
      '{'{3'd0, 3'd0, 1'b1}, PAINT_BY_MODEL},
      '{'{3'd3, 3'd4, 1'b1}, PAINT_BY_MODEL},
      '{'{3'd5, 3'd2, 1'b1}, PAINT_BY_MODEL},
      '{'{3'd5, 3'd2, 1'b1}, PAINT_BY_MODEL},
      '{'{3'd5, 3'd2, 1'b1}, PAINT_BY_MODEL},
      '{'{3'd7, 3'd0, 1'b1}, PAINT_BY_MODEL},
      '{'{3'd0, 3'd7, 1'b1}, PAINT_BY_MODEL},
      '{'{3'd3, 3'd3, 1'b0}, PAINT_NONE},
      '{'{3'd6, 3'd1, 1'b1}, PAINT_BY_MODEL},
      '{'{3'd7, 3'd7, 1'b1}, PAINT_BY_MODEL}
   };

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   logic [COUNT_BITS-1:0] key_count [NKEYS];
   logic [COUNT_BITS-1:0] top_count;
   rsp_type               paint_queue [$];
   int                    mismatch_count = 0;

   key_press_heatmap_colorizer dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // bumps the counter of a pressed key; returns 1 when the grid gets repainted
   function automatic bit count_press(input req_type r);
      int key;
      if (!r.pressed || r.key_row >= ROWS || r.key_col >= COLS)
         return 1'b0;
      key = r.key_row * COLS + r.key_col;
      if (key_count[key] != COUNT_MAX)
         key_count[key]++;
      if (key_count[key] > top_count)
         top_count = key_count[key];
      return 1'b1;
   endfunction

   function automatic rsp_type heat_of(input int k);
      rsp_type        c;
      longint unsigned scaled;
      int unsigned    v;
      v = 0;
      if (top_count != 0) begin
         scaled = key_count[k];
         scaled = (scaled * V_MAX) / top_count;
         if (scaled > V_MAX)
            scaled = V_MAX;
         v = 32'(scaled);
      end
      c.led_row     = ROW_W'(k / COLS);
      c.led_col     = COL_W'(k % COLS);
      c.last_of_run = (k == NKEYS - 1);
      if (v <= RAMP_STEP) begin
         c.red = '0; c.green = CH_W'(v); c.blue = CH_W'(RAMP_STEP);
      end else if (v <= 2 * RAMP_STEP) begin
         c.red = '0; c.green = CH_W'(RAMP_STEP); c.blue = CH_W'(2 * RAMP_STEP - v);
      end else if (v <= 3 * RAMP_STEP) begin
         c.red = CH_W'(v - 2 * RAMP_STEP); c.green = CH_W'(RAMP_STEP); c.blue = '0;
      end else begin
         c.red = CH_W'(RAMP_STEP); c.green = CH_W'(V_MAX - v); c.blue = '0;
      end
      return c;
   endfunction

   task automatic send_key(input req_type r, input paint_check_type how, input int idle_pct);
      bit      paints;
      int      key;
      rsp_type c;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(90, 1)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      paints = count_press(r);
      key    = r.key_row * COLS + r.key_col;
      for (int k = 0; k < NKEYS; k++) begin
         if (how == PAINT_LONE_HOT) begin
            // very first press: that key is full red, the rest pure blue
            c             = '0;
            c.led_row     = ROW_W'(k / COLS);
            c.led_col     = COL_W'(k % COLS);
            c.last_of_run = (k == NKEYS - 1);
            if (k == key)
               c.red = 8'd255;
            else
               c.blue = 8'd255;
            paint_queue.push_back(c);
         end else if (how == PAINT_BY_MODEL && paints) begin
            paint_queue.push_back(heat_of(k));
         end
      end
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (paint_queue.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected color, expected none, actual %p", $time, rsp_data);
         end else begin
            want = paint_queue.pop_front();
            check_field("led_row", want.led_row, rsp_data.led_row);
            check_field("led_col", want.led_col, rsp_data.led_col);
            check_field("red", want.red, rsp_data.red);
            check_field("green", want.green, rsp_data.green);
            check_field("blue", want.blue, rsp_data.blue);
            check_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
         end
      end
   end

   initial begin
      req_type r;
      int      sent;
      int      idle_pct;
      int      wait_cycles;
      foreach (key_count[k])
         key_count[k] = '0;
      top_count = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         send_key(plan[i].req, plan[i].check, 18);

      // random part: corner keys run hot so the ramp spans all segments
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent < RANDOM_ITEMS / 3)
            idle_pct = 18;
         else if (sent < 2 * RANDOM_ITEMS / 3)
            idle_pct = 59;
         else
            idle_pct = 0;
         if ($urandom_range(99) < 40) begin
            r.key_row = ROW_W'($urandom_range(1) * 7);
            r.key_col = COL_W'($urandom_range(1) * 7);
         end else begin
            r.key_row = ROW_W'($urandom_range(7));
            r.key_col = COL_W'($urandom_range(7));
         end
         r.pressed = ($urandom_range(99) < 80);
         sent++;
         send_key(r, PAINT_BY_MODEL, idle_pct);
      end
      start <= 1'b0;

      wait_cycles = 0;
      while (paint_queue.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && paint_queue.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         if (paint_queue.size() != 0)
            $display("%0t: %0d colors never arrived", $time, paint_queue.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
